### rtl/core/arb_pkg.sv
package arb_pkg;

    // default fraction width of the rotation and sphere values
    localparam int FRAC_BITS_DEF = 14;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_Y = 3'd4;

    localparam logic [12:0] WIDTH_RST  = 13'd640;
    localparam logic [12:0] HEIGHT_RST = 13'd480;
    localparam logic [15:0] RADIUS_RST = 16'd256;

    // event codes
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_MOVE  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEN_MUL,
        ST_DEN,
        ST_DIV_WAIT,
        ST_MAG_MUL,
        ST_MAG_ACC,
        ST_SQRT,
        ST_SQRT_WAIT,
        ST_NORM,
        ST_NORM_WAIT,
        ST_MAP_DONE,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_MAC_WB,
        ST_OUT
    } state_t;

    // one multiply-accumulate term of the drag and product sequence
    typedef struct packed {
        logic       phase;  // 0: cross/dot of sphere points, 1: quaternion product
        logic [1:0] sa;
        logic [1:0] sb;
        logic       neg;
        logic       first;
        logic       last;
        logic [1:0] dst;
    } mac_op_t;

    localparam int MAC_STEPS = 25;
    localparam logic [4:0] MAC_LAST_STEP = 5'd24;

    function automatic mac_op_t mk_op(input logic ph, input logic [1:0] sa,
                                      input logic [1:0] sb, input logic neg,
                                      input logic first, input logic last,
                                      input logic [1:0] dst);
        mac_op_t op;
        op.phase = ph;
        op.sa    = sa;
        op.sb    = sb;
        op.neg   = neg;
        op.first = first;
        op.last  = last;
        op.dst   = dst;
        return op;
    endfunction

    function automatic mac_op_t mac_op(input logic [4:0] s);
        mac_op_t op;
        case (s)
            5'd0:    op = mk_op(1'b0, 2'd1, 2'd2, 1'b0, 1'b1, 1'b0, 2'd0);
            5'd1:    op = mk_op(1'b0, 2'd2, 2'd1, 1'b1, 1'b0, 1'b1, 2'd0);
            5'd2:    op = mk_op(1'b0, 2'd2, 2'd0, 1'b0, 1'b1, 1'b0, 2'd1);
            5'd3:    op = mk_op(1'b0, 2'd0, 2'd2, 1'b1, 1'b0, 1'b1, 2'd1);
            5'd4:    op = mk_op(1'b0, 2'd0, 2'd1, 1'b0, 1'b1, 1'b0, 2'd2);
            5'd5:    op = mk_op(1'b0, 2'd1, 2'd0, 1'b1, 1'b0, 1'b1, 2'd2);
            5'd6:    op = mk_op(1'b0, 2'd0, 2'd0, 1'b0, 1'b1, 1'b0, 2'd3);
            5'd7:    op = mk_op(1'b0, 2'd1, 2'd1, 1'b0, 1'b0, 1'b0, 2'd3);
            5'd8:    op = mk_op(1'b0, 2'd2, 2'd2, 1'b0, 1'b0, 1'b1, 2'd3);
            5'd9:    op = mk_op(1'b1, 2'd3, 2'd3, 1'b0, 1'b1, 1'b0, 2'd3);
            5'd10:   op = mk_op(1'b1, 2'd0, 2'd0, 1'b1, 1'b0, 1'b0, 2'd3);
            5'd11:   op = mk_op(1'b1, 2'd1, 2'd1, 1'b1, 1'b0, 1'b0, 2'd3);
            5'd12:   op = mk_op(1'b1, 2'd2, 2'd2, 1'b1, 1'b0, 1'b1, 2'd3);
            5'd13:   op = mk_op(1'b1, 2'd3, 2'd0, 1'b0, 1'b1, 1'b0, 2'd0);
            5'd14:   op = mk_op(1'b1, 2'd0, 2'd3, 1'b0, 1'b0, 1'b0, 2'd0);
            5'd15:   op = mk_op(1'b1, 2'd1, 2'd2, 1'b0, 1'b0, 1'b0, 2'd0);
            5'd16:   op = mk_op(1'b1, 2'd2, 2'd1, 1'b1, 1'b0, 1'b1, 2'd0);
            5'd17:   op = mk_op(1'b1, 2'd3, 2'd1, 1'b0, 1'b1, 1'b0, 2'd1);
            5'd18:   op = mk_op(1'b1, 2'd0, 2'd2, 1'b1, 1'b0, 1'b0, 2'd1);
            5'd19:   op = mk_op(1'b1, 2'd1, 2'd3, 1'b0, 1'b0, 1'b0, 2'd1);
            5'd20:   op = mk_op(1'b1, 2'd2, 2'd0, 1'b0, 1'b0, 1'b1, 2'd1);
            5'd21:   op = mk_op(1'b1, 2'd3, 2'd2, 1'b0, 1'b1, 1'b0, 2'd2);
            5'd22:   op = mk_op(1'b1, 2'd0, 2'd1, 1'b0, 1'b0, 1'b0, 2'd2);
            5'd23:   op = mk_op(1'b1, 2'd1, 2'd0, 1'b1, 1'b0, 1'b0, 2'd2);
            5'd24:   op = mk_op(1'b1, 2'd2, 2'd3, 1'b0, 1'b0, 1'b1, 2'd2);
            default: op = mk_op(1'b1, 2'd0, 2'd0, 1'b0, 1'b1, 1'b1, 2'd0);
        endcase
        return op;
    endfunction

endpackage

### rtl/core/arb_if.sv
interface arb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;

    modport source (output valid, output cmd, output point_x, output point_y, input ready);
    modport sink (input valid, input cmd, input point_x, input point_y, output ready);
endinterface

interface arb_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [15:0] rot_w;
    logic               dragging;

    modport source (output valid, output rot_x, output rot_y, output rot_z, output rot_w,
                    output dragging, input ready);
    modport sink (input valid, input rot_x, input rot_y, input rot_z, input rot_w,
                  input dragging, output ready);
endinterface

### rtl/core/arb_div.sv
module arb_div #(
    parameter int WD = 29,
    parameter int QB = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [WD-1:0] r0,
    input  logic [QB-1:0] feed,
    input  logic [WD-1:0] den,
    output logic          done,
    output logic [QB-1:0] quo
);

    localparam int CW = $clog2(QB);

    logic [WD:0]   rem_reg;
    logic [QB-1:0] feed_reg;
    logic [QB-1:0] quo_reg;
    logic [WD-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;

    logic [WD:0] trial;
    logic        qbit;

    // restoring step: shift in one dividend bit, subtract when it fits
    always_comb
    begin
        trial = {rem_reg[WD-1:0], feed_reg[QB-1]};
        qbit  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(QB - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, r0};
            feed_reg <= feed;
            den_reg  <= den;
            quo_reg  <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= qbit ? (trial - {1'b0, den_reg}) : trial;
            feed_reg <= {feed_reg[QB-2:0], 1'b0};
            quo_reg  <= {quo_reg[QB-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### rtl/core/arb_sqrt.sv
module arb_sqrt #(
    parameter int RB = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RB-1:0] radicand,
    output logic            done,
    output logic [RB-1:0]   root
);

    localparam int RW = RB + 3;
    localparam int CW = $clog2(RB);

    logic [2*RB-1:0] rad_reg;
    logic [RW-1:0]   rem_reg;
    logic [RB-1:0]   root_reg;
    logic [CW-1:0]   cnt_reg;
    logic            run_reg;
    logic            done_reg;

    logic [RW-1:0] rem_t;
    logic [RW-1:0] trial;
    logic          fit;

    // two radicand bits per step, one root bit out
    always_comb
    begin
        rem_t = {rem_reg[RW-3:0], rad_reg[2*RB-1:2*RB-2]};
        trial = RW'({root_reg, 2'b01});
        fit   = rem_t >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(RB - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= {rad_reg[2*RB-3:0], 2'b00};
            rem_reg  <= fit ? (rem_t - trial) : rem_t;
            root_reg <= {root_reg[RB-2:0], fit};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/core/arcball_rotation_tracker.sv
// channel  | dir | handshake    | payload
// ---------+-----+--------------+----------------------------------------------
// req      | in  | valid/ready  | cmd, point_x, point_y
// rsp      | out | valid/ready  | rot_x, rot_y, rot_z, rot_w (low 16 bits), dragging
// cfg      | in  | cfg_we       | cfg_index, cfg_data
//
// end, no-op and rejected events go straight to the output state (ST_OUT)
// begin: each axis numerator is scaled through the divider (skipped when it is zero or
// saturates), then the squared magnitude and its root are formed and, off the ball, both
// axes are normalized by division; move adds the multiply-accumulate; QB = RB = FRAC_BITS+2
// reset gives identity rotation, no drag and the default window registers
// one item at a time; a stalled result holds in the output register and the next item waits in ST_OUT
module arcball_rotation_tracker #(
    parameter int FRAC_BITS = arb_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    arb_in_if.sink                           req,
    arb_out_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [arb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [arb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int F  = FRAC_BITS;
    localparam int VW = F + 3;                  // signed sphere / rotation values
    localparam int MW = (F + 3 > 17) ? F + 3 : 17;
    localparam int PW = 2 * MW;
    localparam int AW = PW + 2;
    localparam int QB = F + 2;                  // quotient and root bits
    localparam int WD = (F + 2 > 29) ? F + 2 : 29;
    localparam int SW = 2 * F + 4;
    localparam int XW = (VW > 16) ? VW : 16;

    localparam logic [QB-1:0]        LIM   = QB'(1) << (F + 1);     // 2.0
    localparam logic [SW-1:0]        ONE2  = SW'(1) << (2 * F);     // 1.0 squared
    localparam logic signed [AW-1:0] HALF  = AW'(1) << (F - 1);
    localparam logic signed [AW-1:0] ALIM  = AW'(1) << F;
    localparam logic signed [AW-1:0] RLIM  = (AW'(1) << (F + 1)) - AW'(1);
    localparam logic signed [VW-1:0] V_ONE = VW'(1) << F;

    // configuration
    logic [12:0]        width_reg;
    logic [12:0]        height_reg;
    logic [15:0]        radius_reg;
    logic signed [15:0] offx_reg;
    logic signed [15:0] offy_reg;

    // tracker state
    logic               drag_reg;
    logic signed [VW-1:0] rnow_reg  [4];
    logic signed [VW-1:0] rdown_reg [4];
    logic signed [VW-1:0] fdown_reg [3];
    logic signed [VW-1:0] to_reg    [3];
    logic signed [VW-1:0] a_reg     [4];

    // sequencer and datapath
    arb_pkg::state_t state_reg, state_next;
    logic [1:0]     cmd_reg;
    logic [17:0]    nmx_reg, nmy_reg;
    logic           nnx_reg, nny_reg;
    logic           axis_reg;
    logic [4:0]     step_reg;
    logic [QB-1:0]  ax_reg, ay_reg, z_reg, s_reg;
    logic           sx_reg, sy_reg, big_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;

    // result register
    logic               ovalid_reg;
    logic [15:0]        orot_reg [4];
    logic               odrag_reg;

    logic in_fire, out_load, map_wr, div_start, sqrt_start;
    logic [QB-1:0] map_q;
    logic          in_win;
    logic signed [18:0] numx, numy;
    logic [17:0]   nm_sel;
    logic          ovf;

    logic          div_done, sqrt_done;
    logic [QB-1:0] div_quo, sqrt_root;
    logic [WD-1:0] div_r0, div_den;
    logic [QB-1:0] div_feed;
    logic [SW-1:0] mag, sqrt_rad;

    arb_pkg::mac_op_t op;
    logic signed [VW-1:0] op_a, op_b;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [AW-1:0] prod_ext, rnd, rnd_sat;
    logic signed [VW-1:0] vec [3];
    logic signed [XW-1:0] rext [4];

    assign in_fire = req.valid && req.ready;
    assign req.ready = (state_reg == arb_pkg::ST_IDLE);

    // window test and centered numerators of the incoming point
    always_comb
    begin
        logic signed [16:0] px, py, ox, oy;
        px = 17'(req.point_x);
        py = 17'(req.point_y);
        ox = 17'(offx_reg);
        oy = 17'(offy_reg);
        in_win = (px >= ox) && (px < ox + 17'($signed({1'b0, width_reg})))
              && (py >= oy) && (py < oy + 17'($signed({1'b0, height_reg})));
        numx = 19'(offx_reg) + 19'($signed({1'b0, width_reg[12:1]})) - 19'(req.point_x);
        numy = 19'(req.point_y) - 19'(offy_reg) - 19'($signed({1'b0, height_reg[12:1]}));
    end

    assign nm_sel = axis_reg ? nmy_reg : nmx_reg;
    assign ovf    = WD'({nm_sel, 7'b0}) >= WD'(prod_reg[28:0]);
    assign mag    = acc_reg[SW-1:0];
    assign sqrt_rad = (mag > ONE2) ? mag : (ONE2 - mag);

    // divider operands: screen-to-ball scaling or rim normalization
    always_comb
    begin
        logic [QB-1:0] am;
        am = axis_reg ? ay_reg : ax_reg;
        if (state_reg == arb_pkg::ST_NORM)
        begin
            div_r0   = WD'(am >> 2);
            div_feed = {am[1:0], F'(0)};
            div_den  = WD'(s_reg);
        end
        else
        begin
            div_r0   = WD'({nm_sel, 7'b0});
            div_feed = '0;
            div_den  = WD'(prod_reg[28:0]);
        end
    end

    // operand pick for the multiply-accumulate sequence
    always_comb
    begin
        op = arb_pkg::mac_op(step_reg);
        if (op.phase)
        begin
            op_a = a_reg[op.sa];
            op_b = rdown_reg[op.sb];
        end
        else
        begin
            case (op.sa)
                2'd0:    op_a = fdown_reg[0];
                2'd1:    op_a = fdown_reg[1];
                default: op_a = fdown_reg[2];
            endcase
            case (op.sb)
                2'd0:    op_b = to_reg[0];
                2'd1:    op_b = to_reg[1];
                default: op_b = to_reg[2];
            endcase
        end
    end

    // shared multiplier inputs
    always_comb
    begin
        case (state_reg)
            arb_pkg::ST_DEN_MUL:
            begin
                mul_a = MW'($signed({1'b0, radius_reg}));
                mul_b = axis_reg ? MW'($signed({1'b0, height_reg}))
                                 : MW'($signed({1'b0, width_reg}));
            end
            arb_pkg::ST_MAG_MUL:
            begin
                mul_a = step_reg[0] ? MW'($signed({1'b0, ay_reg}))
                                    : MW'($signed({1'b0, ax_reg}));
                mul_b = mul_a;
            end
            default:
            begin
                mul_a = MW'(op_a);
                mul_b = MW'(op_b);
            end
        endcase
    end

    // round half up to Q(F), then clamp to the term's limit
    always_comb
    begin
        prod_ext = AW'(prod_reg);
        rnd = (acc_reg + HALF) >>> F;
        if (op.phase)
            rnd_sat = (rnd > RLIM) ? RLIM : ((rnd < -RLIM) ? -RLIM : rnd);
        else
            rnd_sat = (rnd > ALIM) ? ALIM : ((rnd < -ALIM) ? -ALIM : rnd);
    end

    // signed sphere point from magnitudes
    always_comb
    begin
        logic signed [VW-1:0] vx, vy;
        vx = VW'({1'b0, ax_reg});
        vy = VW'({1'b0, ay_reg});
        vec[0] = sx_reg ? -vx : vx;
        vec[1] = sy_reg ? -vy : vy;
        vec[2] = VW'({1'b0, z_reg});
        for (int i = 0; i < 4; i++)
            rext[i] = XW'(rnow_reg[i]);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        map_wr     = 1'b0;
        map_q      = '0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            arb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (req.cmd)
                        arb_pkg::CMD_BEGIN:
                            state_next = in_win ? arb_pkg::ST_DEN_MUL : arb_pkg::ST_OUT;
                        arb_pkg::CMD_MOVE:
                            state_next = drag_reg ? arb_pkg::ST_DEN_MUL : arb_pkg::ST_OUT;
                        default:
                            state_next = arb_pkg::ST_OUT;
                    endcase
                end
            end
            arb_pkg::ST_DEN_MUL:
                state_next = arb_pkg::ST_DEN;
            arb_pkg::ST_DEN:
            begin
                if (nm_sel == '0)
                    map_wr = 1'b1;
                else if (ovf)
                begin
                    map_wr = 1'b1;
                    map_q  = LIM;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = arb_pkg::ST_DIV_WAIT;
                end
            end
            arb_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    map_wr = 1'b1;
                    map_q  = (div_quo > LIM) ? LIM : div_quo;
                end
            end
            arb_pkg::ST_MAG_MUL:
                state_next = arb_pkg::ST_MAG_ACC;
            arb_pkg::ST_MAG_ACC:
                state_next = step_reg[0] ? arb_pkg::ST_SQRT : arb_pkg::ST_MAG_MUL;
            arb_pkg::ST_SQRT:
            begin
                sqrt_start = 1'b1;
                state_next = arb_pkg::ST_SQRT_WAIT;
            end
            arb_pkg::ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                    state_next = big_reg ? arb_pkg::ST_NORM : arb_pkg::ST_MAP_DONE;
            end
            arb_pkg::ST_NORM:
            begin
                div_start  = 1'b1;
                state_next = arb_pkg::ST_NORM_WAIT;
            end
            arb_pkg::ST_NORM_WAIT:
            begin
                if (div_done)
                    state_next = axis_reg ? arb_pkg::ST_MAP_DONE : arb_pkg::ST_NORM;
            end
            arb_pkg::ST_MAP_DONE:
                state_next = (cmd_reg == arb_pkg::CMD_BEGIN) ? arb_pkg::ST_OUT
                                                             : arb_pkg::ST_MAC_MUL;
            arb_pkg::ST_MAC_MUL:
                state_next = arb_pkg::ST_MAC_ACC;
            arb_pkg::ST_MAC_ACC:
                state_next = op.last ? arb_pkg::ST_MAC_WB : arb_pkg::ST_MAC_MUL;
            arb_pkg::ST_MAC_WB:
                state_next = (step_reg == arb_pkg::MAC_LAST_STEP) ? arb_pkg::ST_OUT
                                                                  : arb_pkg::ST_MAC_MUL;
            arb_pkg::ST_OUT:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = arb_pkg::ST_IDLE;
                end
            end
            default:
                state_next = arb_pkg::ST_IDLE;
        endcase
        // a finished axis moves on to the other one or to the magnitude
        if (map_wr)
            state_next = axis_reg ? arb_pkg::ST_MAG_MUL : arb_pkg::ST_DEN_MUL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= arb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration, drag flag and rotation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= arb_pkg::WIDTH_RST;
            height_reg <= arb_pkg::HEIGHT_RST;
            radius_reg <= arb_pkg::RADIUS_RST;
            offx_reg   <= '0;
            offy_reg   <= '0;
            drag_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                rnow_reg[i]  <= '0;
                rdown_reg[i] <= '0;
                fdown_reg[i] <= '0;
            end
            rnow_reg[3]  <= V_ONE;
            rdown_reg[3] <= V_ONE;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    arb_pkg::CFG_WIDTH:    width_reg  <= cfg_data[12:0];
                    arb_pkg::CFG_HEIGHT:   height_reg <= cfg_data[12:0];
                    arb_pkg::CFG_RADIUS:   radius_reg <= cfg_data;
                    arb_pkg::CFG_OFFSET_X: offx_reg   <= cfg_data;
                    arb_pkg::CFG_OFFSET_Y: offy_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (in_fire)
            begin
                if (req.cmd == arb_pkg::CMD_BEGIN && in_win)
                begin
                    drag_reg <= 1'b1;
                    for (int i = 0; i < 4; i++)
                        rdown_reg[i] <= rnow_reg[i];
                end
                else if (req.cmd == arb_pkg::CMD_END)
                    drag_reg <= 1'b0;
            end
            if (state_reg == arb_pkg::ST_MAP_DONE && cmd_reg == arb_pkg::CMD_BEGIN)
            begin
                for (int i = 0; i < 3; i++)
                    fdown_reg[i] <= vec[i];
            end
            if (state_reg == arb_pkg::ST_MAC_WB && op.phase)
                rnow_reg[op.dst] <= rnd_sat[VW-1:0];
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (rsp.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // working registers of one item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            case (state_reg)
                arb_pkg::ST_IDLE:
                begin
                    axis_reg <= 1'b0;
                    step_reg <= '0;
                end
                arb_pkg::ST_MAG_ACC:
                    step_reg <= step_reg + 5'd1;
                arb_pkg::ST_NORM_WAIT:
                    if (div_done)
                        axis_reg <= ~axis_reg;
                arb_pkg::ST_MAP_DONE:
                    step_reg <= '0;
                arb_pkg::ST_MAC_ACC:
                    if (!op.last)
                        step_reg <= step_reg + 5'd1;
                arb_pkg::ST_MAC_WB:
                    step_reg <= step_reg + 5'd1;
                default: ;
            endcase
            if (map_wr)
            begin
                axis_reg <= ~axis_reg;
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= req.cmd;
            nmx_reg <= numx[18] ? 18'(-numx) : numx[17:0];
            nmy_reg <= numy[18] ? 18'(-numy) : numy[17:0];
            nnx_reg <= numx[18];
            nny_reg <= numy[18];
        end
        if (state_reg == arb_pkg::ST_DEN_MUL || state_reg == arb_pkg::ST_MAG_MUL
            || state_reg == arb_pkg::ST_MAC_MUL)
            prod_reg <= mul_a * mul_b;
        if (map_wr)
        begin
            if (axis_reg)
            begin
                ay_reg <= map_q;
                sy_reg <= nny_reg;
            end
            else
            begin
                ax_reg <= map_q;
                sx_reg <= nnx_reg;
            end
        end
        if (state_reg == arb_pkg::ST_MAG_ACC)
            acc_reg <= step_reg[0] ? (acc_reg + prod_ext) : prod_ext;
        if (state_reg == arb_pkg::ST_SQRT)
            big_reg <= mag > ONE2;
        if (state_reg == arb_pkg::ST_SQRT_WAIT && sqrt_done)
        begin
            // off the ball: the root scales the point onto the rim
            if (big_reg)
            begin
                s_reg <= sqrt_root;
                z_reg <= '0;
            end
            else
                z_reg <= sqrt_root;
        end
        if (state_reg == arb_pkg::ST_NORM_WAIT && div_done)
        begin
            if (axis_reg)
                ay_reg <= div_quo;
            else
                ax_reg <= div_quo;
        end
        if (state_reg == arb_pkg::ST_MAP_DONE && cmd_reg != arb_pkg::CMD_BEGIN)
        begin
            for (int i = 0; i < 3; i++)
                to_reg[i] <= vec[i];
        end
        if (state_reg == arb_pkg::ST_MAC_ACC)
            acc_reg <= (op.first ? '0 : acc_reg) + (op.neg ? -prod_ext : prod_ext);
        if (state_reg == arb_pkg::ST_MAC_WB && !op.phase)
            a_reg[op.dst] <= rnd_sat[VW-1:0];
        if (out_load)
        begin
            for (int i = 0; i < 4; i++)
                orot_reg[i] <= rext[i][15:0];
            odrag_reg <= drag_reg;
        end
    end

    arb_div #(
        .WD(WD),
        .QB(QB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .r0    (div_r0),
        .feed  (div_feed),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    arb_sqrt #(
        .RB(QB)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign rsp.valid    = ovalid_reg;
    assign rsp.rot_x    = orot_reg[0];
    assign rsp.rot_y    = orot_reg[1];
    assign rsp.rot_z    = orot_reg[2];
    assign rsp.rot_w    = orot_reg[3];
    assign rsp.dragging = odrag_reg;

    // an end item always leaves the drag off
    a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && req.cmd == arb_pkg::CMD_END |=> !drag_reg)
        else $error("drag still active after end item");

    // the current rotation only changes at product write-back
    a_rot_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != arb_pkg::ST_MAC_WB |=> $stable(rnow_reg[3]) && $stable(rnow_reg[0]))
        else $error("rotation changed outside write-back");

    // one item in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !req.ready)
        else $error("second item taken while busy");

endmodule
